@@ sv/tvps_pkg.sv @@
// Shared types and constants for the timed valve and pump sequencer.
package tvps_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned PhaseW   = 4;

  typedef enum logic [CfgIdxW-1:0] {
    IDX_START_DELAY   = 3'd0,
    IDX_VALVE_TO_PUMP = 3'd1,
    IDX_WATERING_TIME = 3'd2,
    IDX_PUMP_TO_VALVE = 3'd3,
    IDX_PUMP_REST     = 3'd4,
    IDX_REPEAT_COUNT  = 3'd5,
    IDX_TICK_RELOAD   = 3'd6
  } cfg_idx_e;

  localparam logic [7:0]  START_DELAY_RST   = 8'h09;
  localparam logic [7:0]  VALVE_TO_PUMP_RST = 8'h05;
  localparam logic [15:0] WATERING_TIME_RST = 16'h012C;
  localparam logic [7:0]  PUMP_TO_VALVE_RST = 8'h09;
  localparam logic [15:0] PUMP_REST_RST     = 16'h012C;
  localparam logic [7:0]  REPEAT_COUNT_RST  = 8'h04;
  localparam logic [7:0]  TICK_RELOAD_RST   = 8'h09;

  typedef struct packed {
    logic [7:0]  start_delay;
    logic [7:0]  valve_to_pump_delay;
    logic [15:0] watering_time;
    logic [7:0]  pump_to_valve_delay;
    logic [15:0] pump_rest_time;
    logic [7:0]  repeat_count;
    logic [7:0]  tick_reload;
  } cfg_t;

  typedef struct packed {
    logic              valve_on;
    logic              pump_on;
    logic [PhaseW-1:0] phase;
    logic              busy_res;
  } result_t;

endpackage

@@ sv/timed_valve_pump_sequencer.sv @@
// Top level: irrigation valve and pump sequencer with configuration port.
// Output: one result word per accepted tick, registered into the result buffer.
// Throughput: one tick per cycle unless stalled; the phase update is a single registered
// pass. A two-entry result buffer lets ticks keep flowing while one result waits.
// Reset (asynchronous, active low): idle, valve closed, pump off, registers at defaults.
module timed_valve_pump_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          start_request_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          valve_on_o,
  output logic                          pump_on_o,
  output logic [tvps_pkg::PhaseW-1:0]   phase_o,
  output logic                          busy_res_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tvps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tvps_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import tvps_pkg::*;

  cfg_t    cfg;
  result_t res_next, res_out;
  logic    full, step;

  assign in_stall_o = full;
  assign step       = in_valid_i && !full;

  tvps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tvps_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .start_request_i (start_request_i),
    .cfg_i           (cfg),
    .res_o           (res_next)
  );

  tvps_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (step),
    .wr_data_i   (res_next),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (res_out)
  );

  assign valve_on_o = res_out.valve_on;
  assign pump_on_o  = res_out.pump_on;
  assign phase_o    = res_out.phase;
  assign busy_res_o = res_out.busy_res;

endmodule

@@ sv/tvps_cfg.sv @@
// Configuration register file for the sequencer timings.
module tvps_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tvps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tvps_pkg::CfgDataW-1:0] cfg_wdata_i,
  output tvps_pkg::cfg_t                cfg_o
);
  import tvps_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_delay         <= START_DELAY_RST;
      cfg_q.valve_to_pump_delay <= VALVE_TO_PUMP_RST;
      cfg_q.watering_time       <= WATERING_TIME_RST;
      cfg_q.pump_to_valve_delay <= PUMP_TO_VALVE_RST;
      cfg_q.pump_rest_time      <= PUMP_REST_RST;
      cfg_q.repeat_count        <= REPEAT_COUNT_RST;
      cfg_q.tick_reload         <= TICK_RELOAD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        IDX_START_DELAY:   cfg_q.start_delay         <= cfg_wdata_i[7:0];
        IDX_VALVE_TO_PUMP: cfg_q.valve_to_pump_delay <= cfg_wdata_i[7:0];
        IDX_WATERING_TIME: cfg_q.watering_time       <= cfg_wdata_i;
        IDX_PUMP_TO_VALVE: cfg_q.pump_to_valve_delay <= cfg_wdata_i[7:0];
        IDX_PUMP_REST:     cfg_q.pump_rest_time      <= cfg_wdata_i;
        IDX_REPEAT_COUNT:  cfg_q.repeat_count        <= cfg_wdata_i[7:0];
        IDX_TICK_RELOAD:   cfg_q.tick_reload         <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ sv/tvps_core.sv @@
// Phase machine, countdown and tick prescaler, updated once per accepted tick.
module tvps_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic            start_request_i,
  input  tvps_pkg::cfg_t  cfg_i,
  output tvps_pkg::result_t res_o
);
  import tvps_pkg::*;

  typedef enum logic [PhaseW-1:0] {
    PH_IDLE       = 4'd0,
    PH_START_WAIT = 4'd1,
    PH_VALVE_ON   = 4'd2,
    PH_V2P_WAIT   = 4'd3,
    PH_PUMP_ON    = 4'd4,
    PH_WATERING   = 4'd5,
    PH_PUMP_OFF   = 4'd6,
    PH_P2V_WAIT   = 4'd7,
    PH_VALVE_OFF  = 4'd8,
    PH_REST       = 4'd9,
    PH_REST_DONE  = 4'd10
  } phase_e;

  logic [PhaseW-1:0] phase_q, phase_d, phase_s;
  logic [15:0]       cd_q, cd_d, cd_s;
  logic [7:0]        cycles_q, cycles_d, cycles_s;
  logic [7:0]        presc_q, presc_d;
  logic              valve_q, valve_d;
  logic              pump_q, pump_d;
  logic              second;

  function automatic logic [15:0] at_least_one(input logic [15:0] v);
    return (v == 16'd0) ? 16'd1 : v;
  endfunction

  always_comb begin
    // start handling comes first
    phase_s  = phase_q;
    cd_s     = cd_q;
    cycles_s = cycles_q;
    if (start_request_i && (phase_q == PH_IDLE)) begin
      phase_s  = PH_START_WAIT;
      cd_s     = at_least_one({8'd0, cfg_i.start_delay});
      cycles_s = cfg_i.repeat_count;
    end

    second  = (presc_q == 8'd0);
    presc_d = second ? cfg_i.tick_reload : presc_q - 8'd1;

    phase_d  = phase_s;
    cd_d     = cd_s;
    cycles_d = cycles_s;
    valve_d  = valve_q;
    pump_d   = pump_q;

    if (second && (phase_s != PH_IDLE)) begin
      case (phase_s)
        PH_START_WAIT, PH_V2P_WAIT, PH_WATERING, PH_P2V_WAIT, PH_REST: begin
          // count down; the next code follows the waiting one
          if (cd_s > 16'd1) begin
            cd_d = cd_s - 16'd1;
          end else begin
            cd_d    = 16'd0;
            phase_d = phase_s + 4'd1;
          end
        end
        PH_VALVE_ON: begin
          valve_d = 1'b1;
          cd_d    = at_least_one({8'd0, cfg_i.valve_to_pump_delay});
          phase_d = PH_V2P_WAIT;
        end
        PH_PUMP_ON: begin
          pump_d  = 1'b1;
          cd_d    = at_least_one(cfg_i.watering_time);
          phase_d = PH_WATERING;
        end
        PH_PUMP_OFF: begin
          pump_d  = 1'b0;
          cd_d    = at_least_one({8'd0, cfg_i.pump_to_valve_delay});
          phase_d = PH_P2V_WAIT;
        end
        PH_VALVE_OFF: begin
          valve_d = 1'b0;
          cd_d    = at_least_one(cfg_i.pump_rest_time);
          phase_d = PH_REST;
        end
        PH_REST_DONE: begin
          if (cycles_s != 8'd0) begin
            cycles_d = cycles_s - 8'd1;
            cd_d     = at_least_one({8'd0, cfg_i.start_delay});
            phase_d  = PH_START_WAIT;
          end else begin
            phase_d = PH_IDLE;
          end
        end
        default: begin
          // unused code: drop everything and go idle
          valve_d = 1'b0;
          pump_d  = 1'b0;
          cd_d    = 16'd0;
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  assign res_o.valve_on = valve_d;
  assign res_o.pump_on  = pump_d;
  assign res_o.phase    = phase_d;
  assign res_o.busy_res = (phase_d != PH_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      cd_q     <= 16'd0;
      cycles_q <= 8'd0;
      presc_q  <= TICK_RELOAD_RST;
      valve_q  <= 1'b0;
      pump_q   <= 1'b0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      cd_q     <= cd_d;
      cycles_q <= cycles_d;
      presc_q  <= presc_d;
      valve_q  <= valve_d;
      pump_q   <= pump_d;
    end
  end

  a_pump_needs_valve: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pump_q |-> valve_q)
    else $error("pump running with valve closed");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_REST_DONE)
    else $error("phase left the defined range");

  a_wait_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_START_WAIT || phase_q == PH_V2P_WAIT || phase_q == PH_WATERING ||
     phase_q == PH_P2V_WAIT || phase_q == PH_REST) |-> (cd_q != 16'd0))
    else $error("waiting phase with empty countdown");

  a_presc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && presc_q != 8'd0) |=> (presc_q == $past(presc_q) - 8'd1))
    else $error("prescaler did not count down");

  a_start_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && start_request_i && phase_q == PH_IDLE) |=>
    (phase_q == PH_START_WAIT || phase_q == PH_VALVE_ON))
    else $error("start request from idle not honoured");

endmodule

@@ sv/tvps_out_buf.sv @@
// Two-entry result buffer parting the tick side from the result side.
module tvps_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_i,
  input  tvps_pkg::result_t wr_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tvps_pkg::result_t out_data_o
);
  import tvps_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       rd;

  assign full_o      = (count_q == 2'd2);
  assign out_valid_o = (count_q != 2'd0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign rd          = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({wr_i, rd})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule
